### sv/msu_pkg.sv
package msu_pkg;

	localparam int DataWidth = 32;

	typedef logic [DataWidth-1:0] msu_word_t;

	// Status of the merge engine as seen by the top-level sequencer.
	typedef struct packed {
		logic busy;
		logic done;
		logic in_b;
	} msu_merge_status_t;

endpackage

### sv/msu_ram.sv
module msu_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  msu_pkg::msu_word_t    wdata,
	input  logic [AW-1:0]         raddr0,
	input  logic [AW-1:0]         raddr1,
	output msu_pkg::msu_word_t    rdata0,
	output msu_pkg::msu_word_t    rdata1
);
	import msu_pkg::*;

	msu_word_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata0 <= mem_q[raddr0];
		rdata1 <= mem_q[raddr1];
	end

endmodule

### sv/msu_merge.sv
module msu_merge #(
	parameter int CW = 7,
	parameter int AW = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [CW-1:0]               count,
	output msu_pkg::msu_merge_status_t  status,
	output logic [AW-1:0]               raddr_x,
	output logic [AW-1:0]               raddr_y,
	input  msu_pkg::msu_word_t          a_rdata_x,
	input  msu_pkg::msu_word_t          a_rdata_y,
	input  msu_pkg::msu_word_t          b_rdata_x,
	input  msu_pkg::msu_word_t          b_rdata_y,
	output logic                        wr_en,
	output logic                        wr_to_b,
	output logic [AW-1:0]               waddr,
	output msu_pkg::msu_word_t          wdata
);
	import msu_pkg::*;

	localparam int SW = CW + 2;

	localparam logic [2:0] M_IDLE  = 3'd0;
	localparam logic [2:0] M_PASS  = 3'd1;
	localparam logic [2:0] M_PAIR  = 3'd2;
	localparam logic [2:0] M_PRIME = 3'd3;
	localparam logic [2:0] M_RUN   = 3'd4;

	logic [2:0]    state_q;
	logic [CW:0]   w_q;
	logic [CW-1:0] lo_q, mid_q, hi_q, x_q, y_q, k_q;
	logic          in_b_q;
	logic          done_q;

	logic [SW-1:0] cnt_ext, lo_w, lo_2w;
	logic [CW-1:0] mid_n, hi_n, x_n, y_n;
	msu_word_t     dx, dy;
	logic          take_x;

	assign cnt_ext = SW'(count);
	assign lo_w    = SW'(lo_q) + SW'(w_q);
	assign lo_2w   = SW'(lo_q) + (SW'(w_q) << 1);
	assign mid_n   = (lo_w  > cnt_ext) ? count : lo_w[CW-1:0];
	assign hi_n    = (lo_2w > cnt_ext) ? count : lo_2w[CW-1:0];

	assign dx = in_b_q ? b_rdata_x : a_rdata_x;
	assign dy = in_b_q ? b_rdata_y : a_rdata_y;

	assign take_x = (x_q < mid_q) && ((y_q >= hi_q) || ($signed(dx) <= $signed(dy)));

	always_comb begin
		x_n = x_q;
		y_n = y_q;
		if (state_q == M_RUN) begin
			if (take_x) begin
				x_n = x_q + CW'(1);
			end else begin
				y_n = y_q + CW'(1);
			end
		end
	end

	assign raddr_x = x_n[AW-1:0];
	assign raddr_y = y_n[AW-1:0];
	assign wr_en   = (state_q == M_RUN);
	assign wr_to_b = !in_b_q;
	assign waddr   = k_q[AW-1:0];
	assign wdata   = take_x ? dx : dy;

	assign status.busy = (state_q != M_IDLE);
	assign status.done = done_q;
	assign status.in_b = in_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			w_q     <= '0;
			lo_q    <= '0;
			mid_q   <= '0;
			hi_q    <= '0;
			x_q     <= '0;
			y_q     <= '0;
			k_q     <= '0;
			in_b_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (start) begin
						w_q     <= (CW+1)'(1);
						in_b_q  <= 1'b0;
						state_q <= M_PASS;
					end
				end
				M_PASS: begin
					if (w_q < (CW+1)'(count)) begin
						lo_q    <= '0;
						state_q <= M_PAIR;
					end else begin
						done_q  <= 1'b1;
						state_q <= M_IDLE;
					end
				end
				M_PAIR: begin
					if (lo_q >= count) begin
						in_b_q  <= !in_b_q;
						w_q     <= w_q << 1;
						state_q <= M_PASS;
					end else begin
						mid_q   <= mid_n;
						hi_q    <= hi_n;
						x_q     <= lo_q;
						y_q     <= mid_n;
						k_q     <= lo_q;
						state_q <= M_PRIME;
					end
				end
				M_PRIME: begin
					state_q <= M_RUN;
				end
				M_RUN: begin
					x_q <= x_n;
					y_q <= y_n;
					k_q <= k_q + CW'(1);
					if (k_q + CW'(1) == hi_q) begin
						lo_q    <= hi_q;
						state_q <= M_PAIR;
					end
				end
				default: begin
					state_q <= M_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_run_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == M_RUN) |-> (k_q < hi_q))
		else $error("merge write index left its run");
	a_run_source: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == M_RUN) |-> ((x_q < mid_q) || (y_q < hi_q)))
		else $error("merge step with both runs exhausted");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (state_q == M_IDLE))
		else $error("merge started while busy");
`endif

endmodule

### sv/merge_sorter_unit.sv
// Merge sorter. Values arrive on the slave stream one per transfer; the
// transfer with s_tlast high closes the list. Up to MAX_ITEMS values are
// stored; later ones are dropped and the run is flagged on m_tuser.
// The list is then sorted ascending (signed, stable) by bottom-up merge
// passes between two memories and sent on the master stream, with
// m_tlast on the final value and m_tuser held high for the whole run if
// any value was dropped.
// Loading accepts one value per cycle while the sender has one valid.
// Sorting takes ceil(log2 n) passes, each merging pairs of runs with
// one compare-and-write per cycle in the merge engine. Each output value
// is read from the registered memory, captured in the output register
// and held until taken; the next value is read only after that.
// s_tready is high only while a list is being loaded; it stays low from
// the closing transfer until the last sorted value has been taken.
// When the receiver stalls, the output register holds its value and the
// block waits. Reset empties the list and returns to loading.
module merge_sorter_unit #(
	parameter int MAX_ITEMS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // value[31:0]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // sorted_value[31:0]
	output logic        m_tlast,
	output logic        m_tuser   // overflow
);
	import msu_pkg::*;

	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);

	localparam logic [2:0] S_LOAD  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_SORT  = 3'd2;
	localparam logic [2:0] S_RD    = 3'd3;
	localparam logic [2:0] S_CAP   = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	logic [2:0]    state_q;
	logic [CW-1:0] cnt_q, r_q;
	logic          drop_q, res_b_q;
	logic          m_valid_q, m_last_q;
	msu_word_t     m_data_q;

	msu_merge_status_t mstat;
	logic [AW-1:0]     m_raddr_x, m_raddr_y, m_waddr;
	logic              m_wr_en, m_wr_to_b;
	msu_word_t         m_wdata;

	logic          in_xfer;
	logic          a_we, b_we;
	logic [AW-1:0] a_waddr, raddr0, raddr1;
	msu_word_t     a_wdata;
	msu_word_t     a_rd0, a_rd1, b_rd0, b_rd1;

	assign s_tready = (state_q == S_LOAD);
	assign in_xfer  = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;
	assign m_tuser  = drop_q;

	assign a_we    = (in_xfer && (cnt_q < CW'(MAX_ITEMS))) || (m_wr_en && !m_wr_to_b);
	assign a_waddr = (state_q == S_LOAD) ? cnt_q[AW-1:0] : m_waddr;
	assign a_wdata = (state_q == S_LOAD) ? s_tdata : m_wdata;
	assign b_we    = m_wr_en && m_wr_to_b;
	assign raddr0  = (state_q == S_SORT) ? m_raddr_x : r_q[AW-1:0];
	assign raddr1  = m_raddr_y;

	msu_ram #(.DEPTH(MAX_ITEMS), .AW(AW)) u_ram_a (
		.clk    (clk),
		.we     (a_we),
		.waddr  (a_waddr),
		.wdata  (a_wdata),
		.raddr0 (raddr0),
		.raddr1 (raddr1),
		.rdata0 (a_rd0),
		.rdata1 (a_rd1)
	);

	msu_ram #(.DEPTH(MAX_ITEMS), .AW(AW)) u_ram_b (
		.clk    (clk),
		.we     (b_we),
		.waddr  (m_waddr),
		.wdata  (m_wdata),
		.raddr0 (raddr0),
		.raddr1 (raddr1),
		.rdata0 (b_rd0),
		.rdata1 (b_rd1)
	);

	msu_merge #(.CW(CW), .AW(AW)) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (state_q == S_START),
		.count     (cnt_q),
		.status    (mstat),
		.raddr_x   (m_raddr_x),
		.raddr_y   (m_raddr_y),
		.a_rdata_x (a_rd0),
		.a_rdata_y (a_rd1),
		.b_rdata_x (b_rd0),
		.b_rdata_y (b_rd1),
		.wr_en     (m_wr_en),
		.wr_to_b   (m_wr_to_b),
		.waddr     (m_waddr),
		.wdata     (m_wdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			cnt_q     <= '0;
			r_q       <= '0;
			drop_q    <= 1'b0;
			res_b_q   <= 1'b0;
			m_valid_q <= 1'b0;
			m_last_q  <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_xfer) begin
						if (cnt_q < CW'(MAX_ITEMS)) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							drop_q <= 1'b1;
						end
						if (s_tlast) begin
							state_q <= S_START;
						end
					end
				end
				S_START: begin
					state_q <= S_SORT;
				end
				S_SORT: begin
					if (mstat.done) begin
						res_b_q <= mstat.in_b;
						r_q     <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CAP;
				end
				S_CAP: begin
					m_valid_q <= 1'b1;
					m_last_q  <= (r_q + CW'(1) == cnt_q);
					state_q   <= S_OUT;
				end
				S_OUT: begin
					if (m_tready) begin
						m_valid_q <= 1'b0;
						if (m_last_q) begin
							cnt_q   <= '0;
							drop_q  <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							r_q     <= r_q + CW'(1);
							state_q <= S_RD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CAP) begin
			m_data_q <= res_b_q ? b_rd0 : a_rd0;
		end
	end

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("loading and output active together");
	a_sort_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		mstat.busy |-> !s_tready)
		else $error("input open while merge engine busy");
	a_run_end_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (s_tready && (cnt_q == '0)))
		else $error("block did not return to loading after a run");
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_ITEMS))
		else $error("stored count beyond capacity");
`endif

endmodule
